// ===== src/soil_temp_liquid_fraction_assert.svh =====
// Assertion macros for the soil temperature and liquid fraction block.
`ifndef SOIL_TEMP_LIQUID_FRACTION_ASSERT_SVH
`define SOIL_TEMP_LIQUID_FRACTION_ASSERT_SVH
`ifndef SYNTHESIS
`define STLF_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication failed");
`define STLF_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define STLF_ASSERT_IMPLY(label, clk, rst, a, b)
`define STLF_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== src/stlf_pkg.sv =====
// Shared types and constants of the soil temperature and liquid fraction block.
`timescale 1ns / 1ps
package stlf_pkg;
  localparam int TEMP_BITS = 26;
  localparam int NUM_W     = 74;
  localparam int DEN_W     = 52;
  localparam int DSH_W     = DEN_W + TEMP_BITS - 1;
  localparam logic [TEMP_BITS-1:0] TEMP_MAX = {TEMP_BITS{1'b1}};
  localparam logic [16:0] LF_ONE = 17'h10000;

  localparam logic [1:0] PH_FROZEN = 2'd0;
  localparam logic [1:0] PH_PARTLY = 2'd1;
  localparam logic [1:0] PH_THAWED = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic [2:0] REG_CI = 3'd0;
  localparam logic [2:0] REG_CW = 3'd1;
  localparam logic [2:0] REG_LAT = 3'd2;
  localparam logic [2:0] REG_T3 = 3'd3;
  localparam logic [2:0] REG_T0 = 3'd4;

  typedef struct packed {
    logic [1:0]           phase;
    logic [1:0]           status;
    logic                 q_temp;
    logic                 q_lf;
    logic [TEMP_BITS-1:0] temp_fix;
    logic [16:0]          lf_fix;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0]     rem;
    logic [DSH_W-1:0]     dsh;
    logic [TEMP_BITS-1:0] q;
    side_t                side;
  } cell_t;

  typedef struct packed {
    logic [15:0] ci;
    logic [15:0] cw;
    logic [19:0] lat;
    logic [24:0] t3;
    logic [24:0] t0;
  } cfg_t;
endpackage

// ===== src/stlf_front.sv =====
// Energy bounds, branch selection and divider set-up, seven pipeline stages.
`timescale 1ns / 1ps
module stlf_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 v_in,
  input  stlf_pkg::cfg_t       cfg,
  input  logic [22:0]          dry_heat_capacity,
  input  logic [23:0]          layer_depth,
  input  logic [31:0]          water_mass,
  input  logic signed [47:0]   layer_energy,
  output logic                 v_out,
  output stlf_pkg::cell_t      d_out
);
  import stlf_pkg::*;

  logic [6:0] v;

  // stage 1: products of the inputs
  logic [46:0] s1_dry;
  logic [47:0] s1_wci, s1_wc;
  logic [51:0] s1_wl;
  logic [46:0] s1_e;
  logic        s1_neg;
  // stage 2
  logic [48:0] s2_hci, s2_hw, s2_pwl, s2_pwh;
  logic [51:0] s2_wl;
  logic [70:0] s2_ea;
  logic        s2_neg;
  // stage 3
  logic [49:0] s3_uil;
  logic [48:0] s3_uih, s3_hci, s3_hw;
  logic [72:0] s3_wct0;
  logic [51:0] s3_wl;
  logic [70:0] s3_ea;
  logic        s3_neg;
  // stage 4
  logic [73:0] s4_ui3, s4_numt;
  logic [48:0] s4_hci, s4_hw;
  logic [51:0] s4_wl;
  logic [70:0] s4_ea;
  logic        s4_neg;
  // stage 5
  logic [74:0] s5_diff, s5_ul3;
  logic        s5_ui3z;
  logic [73:0] s5_numt;
  logic [48:0] s5_hci, s5_hw;
  logic [51:0] s5_wl;
  logic [70:0] s5_ea;
  logic        s5_neg;
  // stage 6
  logic [NUM_W-1:0] s6_num;
  logic [DEN_W-1:0] s6_den;
  side_t            s6_side;
  logic             s6_gt;
  side_t            side6_next;
  logic [NUM_W-1:0] num6_next;
  logic [DEN_W-1:0] den6_next;
  logic             ovf;
  side_t            side7_next;

  // hold valid bits of each stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], v_in};
    end
  end

  assign s6_gt = {4'b0, s5_ea} > s5_ul3;

  // choose the branch and the quotient operands
  always_comb begin
    side6_next = '0;
    num6_next  = '0;
    den6_next  = '0;
    if (s5_neg) begin
      side6_next.phase  = PH_FROZEN;
      side6_next.status = s5_ui3z ? ST_DIV : ST_SAT;
    end else if (s5_diff[74]) begin
      side6_next.phase  = PH_FROZEN;
      side6_next.q_temp = 1'b1;
      num6_next = {3'b0, s5_ea};
      den6_next = {3'b0, s5_hci};
    end else if (s6_gt) begin
      side6_next.phase = PH_THAWED;
      if (s5_hw == '0) begin
        side6_next.status = ST_DIV;
      end else begin
        side6_next.q_temp = 1'b1;
        side6_next.lf_fix = LF_ONE;
        num6_next = s5_numt;
        den6_next = {3'b0, s5_hw};
      end
    end else begin
      side6_next.phase = PH_PARTLY;
      if (s5_wl == '0) begin
        side6_next.status = ST_DIV;
      end else begin
        side6_next.q_lf     = 1'b1;
        side6_next.temp_fix = {1'b0, cfg.t0};
        num6_next = s5_diff[NUM_W-1:0];
        den6_next = s5_wl;
      end
    end
  end

  // saturate a temperature quotient that needs more than the output width
  assign ovf = {4'b0, s6_num} >= {s6_den, {TEMP_BITS{1'b0}}};
  always_comb begin
    side7_next = s6_side;
    if (ovf && s6_side.q_temp) begin
      side7_next.q_temp   = 1'b0;
      side7_next.temp_fix = TEMP_MAX;
      side7_next.status   = ST_SAT;
    end
  end

  // advance the datapath
  always_ff @(posedge clk) begin
    if (en) begin
      s1_dry <= 47'(dry_heat_capacity) * 47'(layer_depth);
      s1_wci <= 48'(water_mass) * 48'(cfg.ci);
      s1_wc  <= 48'(water_mass) * 48'(cfg.cw);
      s1_wl  <= 52'(water_mass) * 52'(cfg.lat);
      s1_e   <= layer_energy[46:0];
      s1_neg <= layer_energy[47];

      s2_hci <= {2'b0, s1_dry} + {1'b0, s1_wci};
      s2_hw  <= {2'b0, s1_dry} + {1'b0, s1_wc};
      s2_pwl <= 49'(s1_wc[23:0]) * 49'(cfg.t0);
      s2_pwh <= 49'(s1_wc[47:24]) * 49'(cfg.t0);
      s2_wl  <= s1_wl;
      s2_ea  <= {s1_e, 24'b0};
      s2_neg <= s1_neg;

      s3_uil  <= 50'(s2_hci[24:0]) * 50'(cfg.t3);
      s3_uih  <= 49'(s2_hci[48:25]) * 49'(cfg.t3);
      s3_wct0 <= {s2_pwh, 24'b0} + {24'b0, s2_pwl};
      s3_hci  <= s2_hci;
      s3_hw   <= s2_hw;
      s3_wl   <= s2_wl;
      s3_ea   <= s2_ea;
      s3_neg  <= s2_neg;

      s4_ui3  <= {s3_uih, 25'b0} + {24'b0, s3_uil};
      s4_numt <= {3'b0, s3_ea} + {1'b0, s3_wct0};
      s4_hci  <= s3_hci;
      s4_hw   <= s3_hw;
      s4_wl   <= s3_wl;
      s4_ea   <= s3_ea;
      s4_neg  <= s3_neg;

      s5_diff <= {4'b0, s4_ea} - {1'b0, s4_ui3};
      s5_ul3  <= {1'b0, s4_ui3} + {7'b0, s4_wl, 16'b0};
      s5_ui3z <= s4_ui3 == '0;
      s5_numt <= s4_numt;
      s5_hci  <= s4_hci;
      s5_hw   <= s4_hw;
      s5_wl   <= s4_wl;
      s5_ea   <= s4_ea;
      s5_neg  <= s4_neg;

      s6_num  <= num6_next;
      s6_den  <= den6_next;
      s6_side <= side6_next;

      d_out.rem  <= s6_num;
      d_out.dsh  <= {s6_den, {(TEMP_BITS-1){1'b0}}};
      d_out.q    <= '0;
      d_out.side <= side7_next;
    end
  end

  assign v_out = v[6];
endmodule

// ===== src/stlf_div_cell.sv =====
// One restoring division cell: settles one quotient bit per cycle while enabled.
`timescale 1ns / 1ps
module stlf_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            v_in,
  input  stlf_pkg::cell_t d_in,
  output logic            v_out,
  output stlf_pkg::cell_t d_out
);
  import stlf_pkg::*;

  logic ge;

  assign ge = {{(DSH_W-NUM_W){1'b0}}, d_in.rem} >= d_in.dsh;

  // hold valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  // subtract the shifted divisor when it fits, then shift it down
  always_ff @(posedge clk) begin
    if (en) begin
      d_out.rem  <= ge ? d_in.rem - d_in.dsh[NUM_W-1:0] : d_in.rem;
      d_out.dsh  <= d_in.dsh >> 1;
      d_out.q    <= {d_in.q[TEMP_BITS-2:0], ge};
      d_out.side <= d_in.side;
    end
  end
endmodule

// ===== src/soil_temp_liquid_fraction.sv =====
// Top level: configuration registers, front pipeline and divider cell chain.
//
// channel  | handshake            | payload
// cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in       | in_valid/in_ready    | dry_heat_capacity, layer_depth, water_mass, layer_energy
// out      | out_valid/out_ready  | temperature, liquid_fraction, phase, status
//
// One request per cycle while the output is not held; seven set-up stages,
// then one division cell per temperature bit (26).
// The whole pipeline holds while the output waits; the last cell register
// is the output register. Reset clears valid bits and restores the registers.
`timescale 1ns / 1ps
`include "soil_temp_liquid_fraction_assert.svh"
module soil_temp_liquid_fraction (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [22:0]        dry_heat_capacity,
  input  logic [23:0]        layer_depth,
  input  logic [31:0]        water_mass,
  input  logic signed [47:0] layer_energy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [25:0]        temperature,
  output logic [16:0]        liquid_fraction,
  output logic [1:0]         phase,
  output logic [1:0]         status
);
  import stlf_pkg::*;

  cfg_t  cfg;
  logic  en;
  logic  cv [TEMP_BITS+1];
  cell_t cd [TEMP_BITS+1];
  cell_t last;
  logic  res_div, res_thawed, res_partly, res_held;

  assign cfg_ready = 1'b1;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ci  <= 16'd2093;
      cfg.cw  <= 16'd4186;
      cfg.lat <= 20'd334000;
      cfg.t3  <= 25'd17901814;
      cfg.t0  <= 25'd17901158;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CI:  cfg.ci  <= cfg_data[15:0];
        REG_CW:  cfg.cw  <= cfg_data[15:0];
        REG_LAT: cfg.lat <= cfg_data[19:0];
        REG_T3:  cfg.t3  <= cfg_data[24:0];
        REG_T0:  cfg.t0  <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  // advance everything unless a result is stuck at the output
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  stlf_front u_front (
    .clk               (clk),
    .rst               (rst),
    .en                (en),
    .v_in              (in_valid),
    .cfg               (cfg),
    .dry_heat_capacity (dry_heat_capacity),
    .layer_depth       (layer_depth),
    .water_mass        (water_mass),
    .layer_energy      (layer_energy),
    .v_out             (cv[0]),
    .d_out             (cd[0])
  );

  for (genvar i = 0; i < TEMP_BITS; i++) begin : g_cell
    stlf_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .v_in  (cv[i]),
      .d_in  (cd[i]),
      .v_out (cv[i+1]),
      .d_out (cd[i+1])
    );
  end

  // drive result fields from the last cell
  assign last            = cd[TEMP_BITS];
  assign out_valid       = cv[TEMP_BITS];
  assign temperature     = last.side.q_temp ? last.q : last.side.temp_fix;
  assign liquid_fraction = last.side.q_lf ? last.q[16:0] : last.side.lf_fix;
  assign phase           = last.side.phase;
  assign status          = last.side.status;

  // result classes watched by the checks below
  assign res_div    = out_valid && status == ST_DIV;
  assign res_thawed = out_valid && phase == PH_THAWED && status != ST_DIV;
  assign res_partly = out_valid && phase == PH_PARTLY && status == ST_OK;
  assign res_held   = out_valid && !out_ready;

  `STLF_ASSERT_IMPLY(a_div_zero, clk, rst, res_div, temperature == '0 && liquid_fraction == '0)
  `STLF_ASSERT_IMPLY(a_thawed_lf, clk, rst, res_thawed, liquid_fraction == LF_ONE)
  `STLF_ASSERT_IMPLY(a_partly_temp, clk, rst, res_partly, temperature == 26'(cfg.t0))
  `STLF_ASSERT_NEXT(a_hold_result, clk, rst, res_held, out_valid && $stable(temperature) && $stable(status))
endmodule
